@@ rtl/rmv_pkg.sv @@
// Shared constants and result layout for the running mean and variance unit.
`default_nettype none

package rmv_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int MEAN_BITS     = 32;
    localparam int DIFF_BITS     = MEAN_BITS + 1;
    localparam int SUM_BITS      = 64;
    localparam int PROD_BITS     = 48;
    localparam int FRAC_SHIFT    = 16;
    localparam int VAR_BITS      = 32;
    localparam int ROOT_BITS     = 24;

    localparam int DIV_NUM_BITS  = SUM_BITS - FRAC_SHIFT;
    localparam int DIV_DEN_BITS  = COUNT_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_NUM_BITS);

    localparam int SQRT_IN_BITS  = 2 * ROOT_BITS;
    localparam int SQRT_REM_BITS = ROOT_BITS + 2;
    localparam int SQRT_CNT_BITS = $clog2(ROOT_BITS);

    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int RES_BITS      = COUNT_BITS + MEAN_BITS + VAR_BITS + ROOT_BITS + 1;
    localparam int OUT_DATA_BITS = ((RES_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - RES_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [OUT_PAD_BITS-1:0] pad;
        logic                    saturated;
        logic [ROOT_BITS-1:0]    stdev_value;
        logic [VAR_BITS-1:0]     variance_value;
        logic [MEAN_BITS-1:0]    mean_value;
        logic [COUNT_BITS-1:0]   count;
    } rmv_result_t;

endpackage

`default_nettype wire

@@ rtl/running_mean_variance_unit.sv @@
// Top level: Welford running mean and variance with a shared divider and root unit.
// Each request either pushes a signed Q8.8 sample or clears the statistics, and
// yields one result with the count, the Q8.24 mean, the Q16.16 sample variance
// and its Q8.16 floor square root, plus a sticky saturation flag. A clear or the
// first sample after a clear goes straight to the finish state; every later push
// makes two passes through the 48-step serial divider (mean update and
// variance) and the 24-step serial square root. s_tready is high only while the
// sequencer is idle; a finished result waits in the output register, so the next
// request may enter before it is taken.
`default_nettype none

module running_mean_variance_unit
    import rmv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [15:0] sample
    input  logic                     s_tuser,   // [0] op
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata    // count, mean_value, variance_value,
                                                // stdev_value, saturated, zero pad
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_MULT,
        ST_ACC,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [MEAN_BITS-1:0]    mean_reg, mean_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;
    logic                    sat_reg, sat_next;
    logic [MEAN_BITS-1:0]    x_reg, x_next;
    logic [DIFF_BITS-1:0]    d_reg, d_next;
    logic [MEAN_BITS-1:0]    emag_reg, emag_next;
    logic [PROD_BITS-1:0]    prod_reg, prod_next;
    logic [VAR_BITS-1:0]     var_reg, var_next;
    logic [ROOT_BITS-1:0]    root_reg, root_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    rmv_result_t             out_reg, out_next;

    logic [MEAN_BITS-1:0]    x_in;
    logic [COUNT_BITS-1:0]   count_inc;
    logic [DIFF_BITS-1:0]    d_in;
    logic [MEAN_BITS-1:0]    dmag;
    logic [DIFF_BITS:0]      delta;
    logic [DIFF_BITS:0]      new_mean_w;
    logic [MEAN_BITS-1:0]    new_mean;
    logic [DIFF_BITS-1:0]    e_val;
    logic [MEAN_BITS-1:0]    emag;
    logic [2*MEAN_BITS-1:0]  mul_full;
    logic [SUM_BITS:0]       sum_w;

    logic                    div_start;
    logic [DIV_NUM_BITS-1:0] div_dividend;
    logic [DIV_DEN_BITS-1:0] div_divisor;
    logic                    div_done;
    logic [DIV_NUM_BITS-1:0] div_q;
    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [ROOT_BITS-1:0]    sqrt_root;

    assign x_in      = {s_tdata[SAMPLE_BITS-1:0], {(MEAN_BITS - SAMPLE_BITS){1'b0}}};
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign d_in      = {x_in[MEAN_BITS-1], x_in} - {mean_reg[MEAN_BITS-1], mean_reg};
    assign dmag      = d_reg[DIFF_BITS-1] ? MEAN_BITS'(-d_reg) : d_reg[MEAN_BITS-1:0];

    assign delta      = d_reg[DIFF_BITS-1] ? -{1'b0, div_q[DIFF_BITS-1:0]}
                                           : {1'b0, div_q[DIFF_BITS-1:0]};
    assign new_mean_w = {{2{mean_reg[MEAN_BITS-1]}}, mean_reg} + delta;
    assign new_mean   = new_mean_w[MEAN_BITS-1:0];
    assign e_val      = {x_reg[MEAN_BITS-1], x_reg} - {new_mean[MEAN_BITS-1], new_mean};
    assign emag       = e_val[DIFF_BITS-1] ? MEAN_BITS'(-e_val) : e_val[MEAN_BITS-1:0];

    assign mul_full = {{MEAN_BITS{1'b0}}, dmag} * {{MEAN_BITS{1'b0}}, emag_reg};
    assign sum_w    = {1'b0, sum_reg} + {{(SUM_BITS - PROD_BITS + 1){1'b0}}, prod_reg};

    assign div_dividend = (state_reg == ST_VAR_GO) ? sum_reg[SUM_BITS-1:FRAC_SHIFT]
                        : {{(DIV_NUM_BITS - MEAN_BITS){1'b0}}, dmag};
    assign div_divisor  = (state_reg == ST_VAR_GO) ? count_reg - 1'b1 : count_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        mean_next     = mean_reg;
        sum_next      = sum_reg;
        sat_next      = sat_reg;
        x_next        = x_reg;
        d_next        = d_reg;
        emag_next     = emag_reg;
        prod_next     = prod_reg;
        var_next      = var_reg;
        root_next     = root_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        div_start     = 1'b0;
        sqrt_start    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_CLEAR)
                    begin
                        count_next = '0;
                        mean_next  = '0;
                        sum_next   = '0;
                        sat_next   = 1'b0;
                        var_next   = '0;
                        root_next  = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        count_next = count_inc;
                        x_next     = x_in;
                        if (count_inc == COUNT_MAX)
                        begin
                            sat_next = 1'b1;
                        end
                        if (count_inc == COUNT_BITS'(1))
                        begin
                            mean_next  = x_in;
                            sum_next   = '0;
                            var_next   = '0;
                            root_next  = '0;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            d_next     = d_in;
                            state_next = ST_MEAN_GO;
                        end
                    end
                end
            end
            ST_MEAN_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    mean_next  = new_mean;
                    emag_next  = emag;
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                prod_next  = mul_full[2*MEAN_BITS-1:FRAC_SHIFT];
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (sum_w[SUM_BITS])
                begin
                    sum_next = '1;
                    sat_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_w[SUM_BITS-1:0];
                end
                state_next = ST_VAR_GO;
            end
            ST_VAR_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_VAR_WAIT;
            end
            ST_VAR_WAIT:
            begin
                if (div_done)
                begin
                    if (|div_q[DIV_NUM_BITS-1:VAR_BITS])
                    begin
                        var_next = '1;
                    end
                    else
                    begin
                        var_next = div_q[VAR_BITS-1:0];
                    end
                    state_next = ST_ROOT_GO;
                end
            end
            ST_ROOT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    root_next  = sqrt_root;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next.pad            = '0;
                    out_next.saturated      = sat_reg;
                    out_next.stdev_value    = root_reg;
                    out_next.variance_value = var_reg;
                    out_next.mean_value     = mean_reg;
                    out_next.count          = count_reg;
                    m_tvalid_next           = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            mean_reg     <= '0;
            sum_reg      <= '0;
            sat_reg      <= 1'b0;
            x_reg        <= '0;
            d_reg        <= '0;
            emag_reg     <= '0;
            prod_reg     <= '0;
            var_reg      <= '0;
            root_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            mean_reg     <= mean_next;
            sum_reg      <= sum_next;
            sat_reg      <= sat_next;
            x_reg        <= x_next;
            d_reg        <= d_next;
            emag_reg     <= emag_next;
            prod_reg     <= prod_next;
            var_reg      <= var_next;
            root_reg     <= root_next;
            m_tvalid_reg <= m_tvalid_next;
            out_reg      <= out_next;
        end
    end

    rmv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    rmv_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({var_reg, {(SQRT_IN_BITS - VAR_BITS){1'b0}}}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

@@ rtl/rmv_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module rmv_div
    import rmv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIV_NUM_BITS-1:0] dividend,
    input  logic [DIV_DEN_BITS-1:0] divisor,
    output logic                    done,
    output logic [DIV_NUM_BITS-1:0] quotient
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_NUM_BITS-1:0] num_reg;
    logic [DIV_DEN_BITS-1:0] den_reg;
    logic [DIV_DEN_BITS-1:0] rem_reg;
    logic [DIV_DEN_BITS:0]   trial;
    logic                    fits;

    assign trial = {rem_reg, num_reg[DIV_NUM_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(DIV_NUM_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_BITS-2:0], fits};
            if (fits)
            begin
                rem_reg <= DIV_DEN_BITS'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DIV_DEN_BITS-1:0];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

@@ rtl/rmv_sqrt.sv @@
// Iterative floor square root, one root bit per cycle.
`default_nettype none

module rmv_sqrt
    import rmv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [SQRT_IN_BITS-1:0]  radicand,
    output logic                     done,
    output logic [ROOT_BITS-1:0]     root
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [SQRT_CNT_BITS-1:0] cnt_reg;
    logic [SQRT_IN_BITS-1:0]  rad_reg;
    logic [SQRT_REM_BITS-1:0] rem_reg;
    logic [ROOT_BITS-1:0]     root_reg;
    logic [SQRT_REM_BITS+1:0] rem_t;
    logic [SQRT_REM_BITS+1:0] trial;
    logic                     fits;

    assign rem_t = {rem_reg, rad_reg[SQRT_IN_BITS-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = rem_t >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQRT_CNT_BITS'(ROOT_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQRT_IN_BITS-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_BITS-2:0], fits};
            if (fits)
            begin
                rem_reg <= SQRT_REM_BITS'(rem_t - trial);
            end
            else
            begin
                rem_reg <= rem_t[SQRT_REM_BITS-1:0];
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ rtl/rmv_checker.sv @@
// Port-level checker for the running mean and variance unit, with its bind.
`default_nettype none

module rmv_checker
    import rmv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata
);

    rmv_result_t res;
    logic        in_acc;
    logic        out_acc;
    logic [1:0]  pending_reg;

    assign res     = m_tdata;
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("request accepted while a previous one is in progress");

    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid |-> pending_reg != 2'd0) and (pending_reg != 2'd3))
        else $error("result count does not match accepted requests");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.count == '0 |-> res.mean_value == '0 && !res.saturated)
        else $error("empty statistics report nonzero mean or saturation");

    a_small_count_no_var: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.count[COUNT_BITS-1:1] == '0
            |-> res.variance_value == '0 && res.stdev_value == '0)
        else $error("variance reported with fewer than two samples");

endmodule

bind running_mean_variance_unit rmv_checker u_rmv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
